// File: design/rppg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppg_pkg: shared types and constants of the ramped period pulse generator
// Widths, command and register codes, sequencer states and the tick update
// bundle used by the sequencer and the tick datapath.
// ----------------------------------------------------------------------------
package rppg_pkg;

   // Field widths
   localparam int PERIOD_W     = 16;
   localparam int CFG_PERIOD_W = 15;
   localparam int SECONDS_W    = 8;
   localparam int STAMP_W      = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 15;

   // Serial divider: one quotient bit per cycle over the ramp span magnitude
   localparam int DIV_STEPS = CFG_PERIOD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Command codes
   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_PERIOD   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_SECONDS = 2'd3;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_SEND
   } state_type;

   // Next values produced by one tick transaction
   typedef struct packed {
      logic                fired;
      logic [PERIOD_W-1:0] period;
      logic                ramp;
      logic [STAMP_W-1:0]  last_ms;
      logic [STAMP_W-1:0]  last_s;
   } tick_next_type;

endpackage

// File: design/rppg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppg_div: serial restoring divider
// Divides the unsigned ramp span by the ramp seconds, one quotient bit per
// cycle through a single shared subtract and compare.
// ----------------------------------------------------------------------------
module rppg_div
   import rppg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [CFG_PERIOD_W-1:0] dividend,
   input  logic [SECONDS_W-1:0]    divisor,
   output logic                    busy,
   output logic                    done,
   output logic [CFG_PERIOD_W-1:0] quotient
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SECONDS_W-1:0]    rem_ff, rem_in;
   logic [CFG_PERIOD_W-1:0] quo_ff, quo_in;
   logic [SECONDS_W-1:0]    dvs_ff, dvs_in;

   logic [SECONDS_W:0]      trial;
   logic [SECONDS_W:0]      trial_sub;
   logic                    trial_ge;
   logic                    last_step;

   // Shift in the next dividend bit and trial subtract
   assign trial     = {rem_ff, quo_ff[CFG_PERIOD_W-1]};
   assign trial_ge  = trial >= {1'b0, dvs_ff};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign last_step = cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = trial_ge ? trial_sub[SECONDS_W-1:0] : trial[SECONDS_W-1:0];
         quo_in = {quo_ff[CFG_PERIOD_W-2:0], trial_ge};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: design/rppg_tick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppg_tick: tick update datapath
// Decides the pulse from the elapsed milliseconds and applies the once per
// second ramp step with its wrap clamp and end-of-ramp test.
// ----------------------------------------------------------------------------
module rppg_tick
   import rppg_pkg::*;
(
   input  logic                    enable,
   input  logic [CFG_PERIOD_W-1:0] start_period,
   input  logic [CFG_PERIOD_W-1:0] end_period,
   input  logic [PERIOD_W-1:0]     period,
   input  logic                    ramp,
   input  logic [PERIOD_W-1:0]     step,
   input  logic [STAMP_W-1:0]      last_ms,
   input  logic [STAMP_W-1:0]      last_s,
   input  logic [STAMP_W-1:0]      now_ms,
   input  logic [STAMP_W-1:0]      now_s,
   output tick_next_type           next
);

   logic [STAMP_W-1:0]  elapsed;
   logic                fire;
   logic                new_sec;
   logic                step_neg;
   logic                step_pos;
   logic [PERIOD_W-1:0] start_ext;
   logic [PERIOD_W-1:0] end_ext;
   logic [PERIOD_W-1:0] stepped;
   logic [PERIOD_W-1:0] ramped;
   logic                end_hit;

   assign start_ext = {1'b0, start_period};
   assign end_ext   = {1'b0, end_period};

   // Pulse when the wrapped elapsed time exceeds the period
   assign elapsed = now_ms - last_ms;
   assign fire    = enable && (elapsed > period);
   assign new_sec = enable && (now_s != last_s);

   // Step, then clamp a downward wrap to the end period
   assign step_neg = step[PERIOD_W-1];
   assign step_pos = !step_neg && (step != '0);
   assign stepped  = period + step;

   always_comb begin
      if (!ramp) begin
         ramped = period;
      end else if (step_neg && (stepped > start_ext)) begin
         ramped = end_ext;
      end else begin
         ramped = stepped;
      end
   end

   assign end_hit = (step_pos && (ramped >= end_ext)) || (step_neg && (ramped <= end_ext));

   always_comb begin
      next.fired   = fire;
      next.last_ms = fire ? now_ms : last_ms;
      next.last_s  = new_sec ? now_s : last_s;
      next.period  = new_sec ? ramped : period;
      next.ramp    = (new_sec && end_hit) ? 1'b0 : ramp;
   end

endmodule

// File: design/ramped_period_pulse_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramped_period_pulse_generator: pulse stimulus with a ramped period
// Sequencer, configuration registers and state of the pulse generator.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one transaction per command: req_cmd low is a time
//   tick with millisecond and second stamps, req_cmd high restarts the ramp
//   from the configuration registers. Every request gives exactly one rsp
//   transaction with the pulse flag, the period in use and the ramp flag.
//   Registers are written through csr_write_en, csr_index and csr_wdata while
//   the block is idle; a write takes effect at the next edge.
//   Steps: an accepted request is captured, the EXEC state commits a tick or
//   a restart that needs no step, and the SEND state loads the response
//   register, which raises rsp_valid. A restart that ramps instead starts
//   the serial divider, one quotient bit per cycle, and waits in the DIV
//   state until the divider is done before it goes on to SEND.
//   Requests are taken only in the idle state, after the last left SEND.
//   A new request is taken while a finished response still waits on
//   rsp_ready; a stalled receiver holds the next result in the sequencer.
//   Reset clears registers, ramp state and timestamps to zero, constant mode.
// ----------------------------------------------------------------------------
module ramped_period_pulse_generator
   import rppg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [STAMP_W-1:0]     req_now_ms,
   input  logic [STAMP_W-1:0]     req_now_s,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_pulse,
   output logic [PERIOD_W-1:0]    rsp_current_period,
   output logic                   rsp_ramping,
   // configuration port
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers
   logic                    enable_ff;
   logic [CFG_PERIOD_W-1:0] start_ff;
   logic [CFG_PERIOD_W-1:0] end_ff;
   logic [SECONDS_W-1:0]    seconds_ff;

   // Sequencer
   state_type state_ff, state_in;

   // Captured transaction
   logic               item_cmd_ff;
   logic [STAMP_W-1:0] item_ms_ff;
   logic [STAMP_W-1:0] item_s_ff;

   // Generator state
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic                ramp_ff, ramp_in;
   logic [PERIOD_W-1:0] step_ff, step_in;
   logic [STAMP_W-1:0]  last_ms_ff, last_ms_in;
   logic [STAMP_W-1:0]  last_s_ff, last_s_in;
   logic                fired_ff, fired_in;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_pulse_ff;
   logic [PERIOD_W-1:0] rsp_period_ff;
   logic                rsp_ramp_ff;

   // Sequencer controls
   logic req_take;
   logic is_restart;
   logic need_div;
   logic div_start;
   logic tick_commit;
   logic restart_commit;
   logic div_commit;
   logic rsp_load;
   logic rsp_free;

   // Divider and tick datapath
   logic                    span_neg;
   logic [CFG_PERIOD_W-1:0] span_mag;
   logic                    div_busy;
   logic                    div_done;
   logic [CFG_PERIOD_W-1:0] div_quo;
   logic [PERIOD_W-1:0]     quo_ext;
   logic [PERIOD_W-1:0]     step_new;
   tick_next_type           tick_next;

   assign req_take   = req_valid && req_ready;
   assign is_restart = item_cmd_ff == CMD_RESTART;
   assign need_div   = (start_ff != end_ff) && (seconds_ff != '0);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         start_ff   <= '0;
         end_ff     <= '0;
         seconds_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ENABLE:       enable_ff  <= csr_wdata[0];
            CSR_START_PERIOD: start_ff   <= csr_wdata[CFG_PERIOD_W-1:0];
            CSR_END_PERIOD:   end_ff     <= csr_wdata[CFG_PERIOD_W-1:0];
            CSR_RAMP_SECONDS: seconds_ff <= csr_wdata[SECONDS_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = (is_restart && need_div) ? ST_DIV : ST_SEND;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready      = 1'b0;
      div_start      = 1'b0;
      tick_commit    = 1'b0;
      restart_commit = 1'b0;
      div_commit     = 1'b0;
      rsp_load       = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EXEC: begin
            tick_commit    = !is_restart;
            restart_commit = is_restart && !need_div;
            div_start      = is_restart && need_div;
         end
         ST_DIV:  div_commit = div_done;
         ST_SEND: rsp_load   = rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_cmd_ff <= req_cmd;
         item_ms_ff  <= req_now_ms;
         item_s_ff   <= req_now_s;
      end
   end

   // Ramp span magnitude and direction
   assign span_neg = end_ff < start_ff;
   assign span_mag = span_neg ? (start_ff - end_ff) : (end_ff - start_ff);

   rppg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (span_mag),
      .divisor  (seconds_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Apply the sign to the truncated quotient
   assign quo_ext  = {1'b0, div_quo};
   assign step_new = span_neg ? (~quo_ext + PERIOD_W'(1)) : quo_ext;

   rppg_tick u_tick (
      .enable       (enable_ff),
      .start_period (start_ff),
      .end_period   (end_ff),
      .period       (period_ff),
      .ramp         (ramp_ff),
      .step         (step_ff),
      .last_ms      (last_ms_ff),
      .last_s       (last_s_ff),
      .now_ms       (item_ms_ff),
      .now_s        (item_s_ff),
      .next         (tick_next)
   );

   // Update generator state
   always_comb begin
      period_in  = period_ff;
      ramp_in    = ramp_ff;
      step_in    = step_ff;
      last_ms_in = last_ms_ff;
      last_s_in  = last_s_ff;
      fired_in   = fired_ff;
      if (tick_commit) begin
         period_in  = tick_next.period;
         ramp_in    = tick_next.ramp;
         last_ms_in = tick_next.last_ms;
         last_s_in  = tick_next.last_s;
         fired_in   = tick_next.fired;
      end else if (restart_commit) begin
         fired_in = 1'b0;
         ramp_in  = 1'b0;
         if (start_ff == end_ff) begin
            period_in = {1'b0, start_ff};
         end else begin
            period_in = {1'b0, end_ff};
            step_in   = '0;
         end
      end else if (div_commit) begin
         fired_in  = 1'b0;
         ramp_in   = 1'b1;
         period_in = {1'b0, start_ff};
         step_in   = step_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= '0;
         ramp_ff    <= 1'b0;
         step_ff    <= '0;
         last_ms_ff <= '0;
         last_s_ff  <= '0;
         fired_ff   <= 1'b0;
      end else begin
         period_ff  <= period_in;
         ramp_ff    <= ramp_in;
         step_ff    <= step_in;
         last_ms_ff <= last_ms_in;
         last_s_ff  <= last_s_in;
         fired_ff   <= fired_in;
      end
   end

   // Response register: load when free, drop on acceptance
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pulse_ff  <= fired_ff;
         rsp_period_ff <= period_ff;
         rsp_ramp_ff   <= ramp_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pulse          = rsp_pulse_ff;
   assign rsp_current_period = rsp_period_ff;
   assign rsp_ramping        = rsp_ramp_ff;

   // Divider completes only while the sequencer waits on it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // No divide still running when a response is sent
   a_send_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> !div_busy)
      else $error("response sent while the divider is busy");

   // A disabled tick leaves the timestamps untouched
   a_disabled_tick_hold: assert property (@(posedge clock) disable iff (reset)
      (tick_commit && !enable_ff) |=> ($stable(last_ms_ff) && $stable(last_s_ff)
                                       && $stable(period_ff)))
      else $error("disabled tick changed generator state");

   // A restart never reports a pulse
   a_restart_no_pulse: assert property (@(posedge clock) disable iff (reset)
      (restart_commit || div_commit) |=> !fired_ff)
      else $error("restart produced a pulse");

endmodule
